FILE: hdl/bzyx_pkg.sv
// Shared constants, types and command structs for the cubic Bezier y-for-x sampler.
package bzyx_pkg;

   // Coordinate format: signed Q7.16.
   localparam int COORD_FRAC_BITS = 16;
   localparam int COORD_W         = COORD_FRAC_BITS + 8;

   // Curve parameter t: unsigned Q0.16; u = 1 - t needs one more bit.
   localparam int T_W = 16;
   localparam int U_W = T_W + 1;

   // Internal arithmetic widths.
   localparam int SQ_W     = 2 * U_W;           // u*u, u*t, t*t
   localparam int CUBE_W   = 3 * U_W;           // raw cubic weights
   localparam int TRIPLE_W = CUBE_W + 2;        // 3 * raw weight
   localparam int WR_W     = 2 * T_W + 1;       // rounded Q0.32 weight, up to 1.0
   localparam int PROD_W   = WR_W + 1 + COORD_W; // weight times coordinate
   localparam int ACC_W    = PROD_W + 2;        // sum of four products
   localparam int RND_W    = ACC_W - 2 * T_W;   // sum after the Q0.32 shift

   // Pipeline registers from a new t to the registered evaluation result.
   localparam int PIPE_DEPTH = 5;

   // Default number of bisection steps.
   localparam int BISECT_STEPS_DEF = 16;

   // Register file and bus.
   localparam int NUM_REGS   = 8;
   localparam int CSR_ADDR_W = $clog2(NUM_REGS) + 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [COORD_W-1:0] COORD_ONE = COORD_W'(1) << COORD_FRAC_BITS;
   localparam logic [U_W-1:0]     T_ONE     = U_W'(1) << T_W;
   localparam logic [T_W-1:0]     T_HALF    = T_W'(1) << (T_W - 1);

   typedef enum logic [2:0] {
      REG_START_X,
      REG_START_Y,
      REG_CTRL1_X,
      REG_CTRL1_Y,
      REG_CTRL2_X,
      REG_CTRL2_Y,
      REG_END_X,
      REG_END_Y
   } reg_index_type;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef coord_type [3:0]           coord_quad_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FILL,
      S_DECIDE,
      S_YFILL,
      S_DONE
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture the request and start the search
      logic decide;  // compare x(mid) with the target
      logic last;    // final decision: hold t and switch to y
      logic emit;    // move the result into the output register
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;  // output register can take a result this cycle
   } dp_status_type;

endpackage

FILE: hdl/bzyx_regs.sv
// Configuration register file holding the four control points.
module bzyx_regs (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bzyx_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bzyx_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bzyx_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready,
   output bzyx_pkg::coord_quad_type        x_pts,
   output bzyx_pkg::coord_quad_type        y_pts
);
   import bzyx_pkg::*;

   logic [COORD_W-1:0]          cfg_ff [NUM_REGS];
   logic [$clog2(NUM_REGS)-1:0] reg_idx;
   logic                        wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   // Register writes; reset restores the default curve.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            cfg_ff[i] <= (i >= int'(REG_CTRL2_X)) ? COORD_ONE : '0;
         end
      end else if (wr_en) begin
         cfg_ff[reg_idx] <= pwdata[COORD_W-1:0];
      end
   end

   // Read back, zero extended to the bus width.
   assign prdata = CSR_DATA_W'(cfg_ff[reg_idx]);

   // Points in Bernstein order: start, first control, second control, end.
   assign x_pts = {cfg_ff[REG_END_X], cfg_ff[REG_CTRL2_X],
                   cfg_ff[REG_CTRL1_X], cfg_ff[REG_START_X]};
   assign y_pts = {cfg_ff[REG_END_Y], cfg_ff[REG_CTRL2_Y],
                   cfg_ff[REG_CTRL1_Y], cfg_ff[REG_START_Y]};

endmodule

FILE: hdl/bzyx_datapath.sv
// Bisection registers, Bernstein evaluation pipeline and output register.
module bzyx_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  bzyx_pkg::dp_cmd_type      cmd,
   output bzyx_pkg::dp_status_type   status,
   input  bzyx_pkg::coord_type       req_target_x,
   input  bzyx_pkg::coord_quad_type  x_pts,
   input  bzyx_pkg::coord_quad_type  y_pts,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output bzyx_pkg::coord_type       rsp_y_value,
   output logic [bzyx_pkg::T_W-1:0]  rsp_param_t
);
   import bzyx_pkg::*;

   localparam logic [TRIPLE_W-1:0]     W_RND  = TRIPLE_W'(1) << (T_W - 1);
   localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(1) << (2 * T_W - 1);
   localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(2 ** (COORD_W - 1) - 1);
   localparam logic signed [RND_W-1:0] SAT_LO = RND_W'(-(2 ** (COORD_W - 1)));

   // Rounds a Q0.48 weight half up to Q0.32.
   function automatic logic [WR_W-1:0] round_weight(input logic [TRIPLE_W-1:0] v);
      logic [TRIPLE_W-1:0] sum;
      sum = v + W_RND;
      return sum[T_W +: WR_W];
   endfunction

   // Search state.
   coord_type        target_ff;
   logic [U_W-1:0]   low_ff;
   logic [U_W-1:0]   high_ff;
   logic [T_W-1:0]   t_ff;
   logic             y_mode_ff;

   // Pipeline registers.
   logic [U_W-1:0]    u_a_ff;
   logic [T_W-1:0]    t_a_ff;
   logic [SQ_W-1:0]   uu_ff;
   logic [SQ_W-1:0]   ut_ff;
   logic [SQ_W-1:0]   tt_ff;
   logic [CUBE_W-1:0] w_ff [4];
   logic [WR_W-1:0]   wr_ff [4];
   logic signed [PROD_W-1:0] prod_ff [4];
   coord_type         result_ff;

   // Output register.
   logic              rsp_valid_ff;
   coord_type         rsp_y_ff;
   logic [T_W-1:0]    rsp_t_ff;

   logic [U_W-1:0]    u_cur;
   logic              below;
   logic [U_W-1:0]    low_sel;
   logic [U_W-1:0]    high_sel;
   logic [U_W:0]      mid_sum;
   coord_type         c_sel [4];
   logic signed [ACC_W-1:0] acc;
   logic signed [RND_W-1:0] rnd;
   coord_type         sat;

   // Next midpoint after the comparison of x(mid) with the target.
   assign below    = result_ff < target_ff;
   assign low_sel  = below ? {1'b0, t_ff} : low_ff;
   assign high_sel = below ? high_ff : {1'b0, t_ff};
   assign mid_sum  = {1'b0, low_sel} + {1'b0, high_sel};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         target_ff <= req_target_x;
         low_ff    <= '0;
         high_ff   <= T_ONE;
         t_ff      <= T_HALF;
         y_mode_ff <= 1'b0;
      end else if (cmd.decide) begin
         if (cmd.last) begin
            y_mode_ff <= 1'b1;
         end else begin
            low_ff  <= low_sel;
            high_ff <= high_sel;
            t_ff    <= mid_sum[T_W:1];
         end
      end
   end

   // Stage A: squares and cross product of t and u = 1 - t.
   assign u_cur = T_ONE - {1'b0, t_ff};

   always_ff @(posedge clock) begin
      u_a_ff <= u_cur;
      t_a_ff <= t_ff;
      uu_ff  <= SQ_W'(u_cur) * SQ_W'(u_cur);
      ut_ff  <= SQ_W'(u_cur) * SQ_W'(t_ff);
      tt_ff  <= SQ_W'(t_ff) * SQ_W'(t_ff);
   end

   // Stage B: raw cubic terms u^3, u^2 t, u t^2, t^3 in Q0.48.
   always_ff @(posedge clock) begin
      w_ff[0] <= CUBE_W'(uu_ff) * CUBE_W'(u_a_ff);
      w_ff[1] <= CUBE_W'(uu_ff) * CUBE_W'(t_a_ff);
      w_ff[2] <= CUBE_W'(tt_ff) * CUBE_W'(u_a_ff);
      w_ff[3] <= CUBE_W'(tt_ff) * CUBE_W'(t_a_ff);
   end

   // Stage C: Bernstein coefficients of three on the middle terms, then rounding.
   always_ff @(posedge clock) begin
      wr_ff[0] <= round_weight(TRIPLE_W'(w_ff[0]));
      wr_ff[1] <= round_weight({w_ff[1], 1'b0} + TRIPLE_W'(w_ff[1]));
      wr_ff[2] <= round_weight({w_ff[2], 1'b0} + TRIPLE_W'(w_ff[2]));
      wr_ff[3] <= round_weight(TRIPLE_W'(w_ff[3]));
   end

   // Stage D: weight times the x or y coordinate of each point.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         c_sel[k] = y_mode_ff ? y_pts[k] : x_pts[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         prod_ff[k] <= PROD_W'($signed({1'b0, wr_ff[k]})) * PROD_W'(c_sel[k]);
      end
   end

   // Stage E: exact sum, round half up to Q7.16 and saturate.
   assign acc = ACC_W'(prod_ff[0]) + ACC_W'(prod_ff[1]) + ACC_W'(prod_ff[2]) +
                ACC_W'(prod_ff[3]) + ACC_RND;
   assign rnd = $signed(acc[ACC_W-1:2*T_W]);

   always_comb begin
      if (rnd > SAT_HI) begin
         sat = SAT_HI[COORD_W-1:0];
      end else if (rnd < SAT_LO) begin
         sat = SAT_LO[COORD_W-1:0];
      end else begin
         sat = rnd[COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= sat;
   end

   // Output register: holds the response until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_y_ff <= result_ff;
         rsp_t_ff <= t_ff;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_y_value     = rsp_y_ff;
   assign rsp_param_t     = rsp_t_ff;

endmodule

FILE: hdl/bzyx_ctrl.sv
// Sequencer for the bisection steps, the final y evaluation and the response.
module bzyx_ctrl #(
   parameter int BISECT_STEPS = bzyx_pkg::BISECT_STEPS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  bzyx_pkg::dp_status_type status,
   output bzyx_pkg::dp_cmd_type    cmd
);
   import bzyx_pkg::*;

   localparam int ITER_W  = $clog2(BISECT_STEPS);
   localparam int STAGE_W = $clog2(PIPE_DEPTH + 1);

   ctrl_state_type     state_ff, state_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;
   logic [STAGE_W-1:0] stage_ff, stage_in;

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         iter_ff  <= '0;
         stage_ff <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
         stage_ff <= stage_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in  = state_ff;
      iter_in   = iter_ff;
      stage_in  = stage_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               iter_in  = '0;
               stage_in = '0;
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            stage_in = stage_ff + 1'b1;
            if (stage_ff == STAGE_W'(PIPE_DEPTH - 1)) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            stage_in   = '0;
            if (iter_ff == ITER_W'(BISECT_STEPS - 1)) begin
               cmd.last = 1'b1;
               state_in = S_YFILL;
            end else begin
               iter_in  = iter_ff + 1'b1;
               state_in = S_FILL;
            end
         end
         S_YFILL: begin
            stage_in = stage_ff + 1'b1;
            if (stage_ff == STAGE_W'(PIPE_DEPTH - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/bezier_y_for_x_core.sv
// Top level of the cubic Bezier y-for-x sampler.
//
//   Channel  Dir     Handshake                 Payload
//   req      in      req_valid / req_stall     req_target_x
//   rsp      out     rsp_valid / rsp_stall     rsp_y_value, rsp_param_t
//   csr      in/out  psel, penable, pready     paddr, pwrite, pwdata, prdata
//
// One request is in flight at a time. Each bisection step passes through the shared
// weight and multiply pipeline and ends in a decision state. After the last
// decision t is held, y is evaluated through the same pipeline and the result is
// moved into the output register; the sequencer then idles to take the next request.
// Reset is synchronous; it idles the sequencer, empties the output register and
// restores the default curve. A stalled response waits in the output register
// while the next request is taken; a finished search holds until it is free.
module bezier_y_for_x_core #(
   parameter int BISECT_STEPS = bzyx_pkg::BISECT_STEPS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  bzyx_pkg::coord_type             req_target_x,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output bzyx_pkg::coord_type             rsp_y_value,
   output logic [bzyx_pkg::T_W-1:0]        rsp_param_t,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bzyx_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bzyx_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bzyx_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import bzyx_pkg::*;

   coord_quad_type x_pts;
   coord_quad_type y_pts;
   dp_cmd_type     cmd;
   dp_status_type  status;

   bzyx_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .x_pts   (x_pts),
      .y_pts   (y_pts)
   );

   bzyx_ctrl #(
      .BISECT_STEPS (BISECT_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bzyx_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_target_x (req_target_x),
      .x_pts        (x_pts),
      .y_pts        (y_pts),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_y_value  (rsp_y_value),
      .rsp_param_t  (rsp_param_t)
   );

endmodule

FILE: hdl/bzyx_checker.sv
// Port-level checks for the sampler, bound to the top level.
module bzyx_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input bzyx_pkg::coord_type             rsp_y_value,
   input logic [bzyx_pkg::T_W-1:0]        rsp_param_t,
   input logic                            psel,
   input logic                            penable,
   input logic                            pwrite,
   input logic [bzyx_pkg::CSR_ADDR_W-1:0] paddr,
   input logic [bzyx_pkg::CSR_DATA_W-1:0] pwdata,
   input logic [bzyx_pkg::CSR_DATA_W-1:0] prdata,
   input logic                            pready
);
   import bzyx_pkg::*;

   // An accepted request keeps the block busy in the next cycle.
   a_busy_after_accept: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall
   ) else $error("request accepted while a search was still starting");

   // A response only appears at the end of a search, never from idle.
   a_rsp_from_search: assert property (
      @(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall)
   ) else $error("response appeared without a search in progress");

   // A stalled response stays and holds its payload.
   a_rsp_hold: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_y_value) && $stable(rsp_param_t))
   ) else $error("stalled response changed or dropped");

   // A register read right after a write returns the written coordinate.
   a_csr_readback: assert property (
      @(posedge clock) disable iff (reset)
      (psel && penable && pwrite && pready) ##1
         (psel && !pwrite && paddr == $past(paddr)) |->
         prdata == CSR_DATA_W'($past(pwdata[COORD_W-1:0]))
   ) else $error("register read back differs from last write");

endmodule

bind bezier_y_for_x_core bzyx_checker u_bzyx_checker (.*);
